// ===== rtl/srle_pkg.sv =====
package srle_pkg;

	// Field widths of one run word
	localparam int COLOR_W = 8;
	localparam int LEN_W   = 14;
	localparam int COORD_W = 16;
	localparam int BYTE_W  = 8;

	// Packed output tdata: colour, length, row, start column, padded to bytes
	localparam int RES_BITS   = COLOR_W + LEN_W + 2 * COORD_W;
	localparam int M_TDATA_W  = ((RES_BITS + 7) / 8) * 8;

	// One decoded run or line end
	typedef struct packed {
		logic [COORD_W-1:0] start_column;
		logic [COORD_W-1:0] row;
		logic [LEN_W-1:0]   run_length;
		logic [COLOR_W-1:0] color_index;
		logic               end_of_line;
		logic               overflow;
	} srle_res_t;

	// Geometry registers handed to the decoder
	typedef struct packed {
		logic [COORD_W-1:0] image_width;
		logic [COORD_W-1:0] image_height;
	} srle_cfg_t;

endpackage

// ===== rtl/srle_apb_regs.sv =====
module srle_apb_regs
	import srle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output srle_cfg_t   cfg
);

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;
	localparam logic [COORD_W-1:0] WIDTH_RST  = 16'd1920;
	localparam logic [COORD_W-1:0] HEIGHT_RST = 16'd1080;

	logic [COORD_W-1:0] width_q;
	logic [COORD_W-1:0] height_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[COORD_W-1:0];
				REG_HEIGHT: height_q <= pwdata[COORD_W-1:0];
				default:    ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = {16'd0, width_q};
			REG_HEIGHT: prdata = {16'd0, height_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign cfg.image_width  = width_q;
	assign cfg.image_height = height_q;

endmodule

// ===== rtl/srle_decode.sv =====
module srle_decode
	import srle_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  srle_cfg_t         cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              in_last,
	output logic              res_valid,
	input  logic              res_ready,
	output srle_res_t         res
);

	typedef enum logic [6:0] {
		PH_NORMAL      = 7'b0000001,
		PH_ESCAPE      = 7'b0000010,
		PH_LONG0_LOW   = 7'b0000100,
		PH_SHORT_COLOR = 7'b0001000,
		PH_LONGC_LOW   = 7'b0010000,
		PH_LONGC_COLOR = 7'b0100000,
		PH_DONE        = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		SEL_SHORT0 = 2'b00,
		SEL_LONG0  = 2'b01,
		SEL_SHORTC = 2'b10,
		SEL_LONGC  = 2'b11
	} sel_t;

	localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h00;
	localparam logic [BYTE_W-1:0] SEL_MASK = 8'hC0;
	localparam logic [BYTE_W-1:0] LOW_MASK = 8'h3F;
	localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
	localparam int END_W = COORD_W + 1;

	// Input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// Decoder state
	phase_t                phase_q, phase_d;
	logic [LEN_W-1:0]      pend_q, pend_d;
	logic [COORD_BITS-1:0] line_q, line_d;
	logic [COORD_BITS-1:0] col_q, col_d;

	logic                  fire;
	logic                  run_do;
	logic                  eol_do;
	logic [COLOR_W-1:0]    run_color;
	logic [LEN_W-1:0]      run_len;
	logic [END_W-1:0]      run_end;
	logic [COORD_BITS-1:0] line_inc;
	sel_t                  sel;
	logic [5:0]            low;

	assign fire     = valid_s1 & res_ready;
	assign in_ready = ~valid_s1 | fire;

	// Take a new word whenever the register is empty or the held one moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	assign sel      = sel_t'((byte_s1 & SEL_MASK) >> 6);
	assign low      = 6'(byte_s1 & LOW_MASK);
	assign run_end  = END_W'(col_q) + END_W'(run_len);
	assign line_inc = (line_q < COORD_MAX) ? line_q + 1'b1 : line_q;

	// Decode the held byte against the current phase
	always_comb begin
		phase_d   = phase_q;
		pend_d    = pend_q;
		line_d    = line_q;
		col_d     = col_q;
		run_do    = 1'b0;
		eol_do    = 1'b0;
		run_color = '0;
		run_len   = '0;
		unique case (phase_q)
			PH_NORMAL: begin
				if (byte_s1 == ESC_BYTE) begin
					phase_d = PH_ESCAPE;
				end else begin
					run_do    = 1'b1;
					run_color = byte_s1;
					run_len   = LEN_W'(1);
				end
			end
			PH_ESCAPE: begin
				if (byte_s1 == ESC_BYTE) begin
					eol_do = 1'b1;
				end else begin
					case (sel)
						SEL_SHORT0: begin
							run_do  = 1'b1;
							run_len = LEN_W'(low);
						end
						SEL_LONG0: begin
							pend_d  = {low, 8'h00};
							phase_d = PH_LONG0_LOW;
						end
						SEL_SHORTC: begin
							pend_d  = LEN_W'(low);
							phase_d = PH_SHORT_COLOR;
						end
						default: begin
							pend_d  = {low, 8'h00};
							phase_d = PH_LONGC_LOW;
						end
					endcase
				end
			end
			PH_LONG0_LOW: begin
				run_do  = 1'b1;
				run_len = {pend_q[LEN_W-1:8], byte_s1};
			end
			PH_SHORT_COLOR, PH_LONGC_COLOR: begin
				run_do    = 1'b1;
				run_color = byte_s1;
				run_len   = pend_q;
			end
			PH_LONGC_LOW: begin
				pend_d  = {pend_q[LEN_W-1:8], byte_s1};
				phase_d = PH_LONGC_COLOR;
			end
			PH_DONE: ;
			default: ;
		endcase

		// Advance the column past a run, saturating
		if (run_do) begin
			col_d   = (run_end > END_W'(COORD_MAX)) ? COORD_MAX : run_end[COORD_BITS-1:0];
			phase_d = PH_NORMAL;
		end

		// Step to the next line; stop once the height is reached
		if (eol_do) begin
			line_d  = line_inc;
			col_d   = '0;
			phase_d = (COORD_W'(line_inc) == cfg.image_height) ? PH_DONE : PH_NORMAL;
		end

		// Drop everything at the end of the object
		if (last_s1) begin
			phase_d = PH_NORMAL;
			pend_d  = '0;
			line_d  = '0;
			col_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			pend_q  <= '0;
			line_q  <= '0;
			col_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			pend_q  <= pend_d;
			line_q  <= line_d;
			col_q   <= col_d;
		end
	end

	// Result word for the output register
	assign res_valid        = fire & (run_do | eol_do);
	assign res.color_index  = run_color;
	assign res.run_length   = run_len;
	assign res.row          = COORD_W'(line_q);
	assign res.start_column = COORD_W'(col_q);
	assign res.end_of_line  = eol_do;
	assign res.overflow     = run_do & (run_end > {1'b0, cfg.image_width});

	// A last byte leaves the counters cleared
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> line_q == '0 && col_q == '0 && phase_q == PH_NORMAL)
		else $error("counters not cleared after last byte");

	// Nothing is reported once the height has been reached
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |-> !res_valid)
		else $error("result produced after final line");

	// A line end never flags overflow and never carries a run
	a_eol_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.end_of_line |-> !res.overflow && res.run_length == '0 && !run_do)
		else $error("malformed line end result");

	// A line end resets the column
	a_eol_col: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eol_do |=> col_q == '0)
		else $error("column not cleared at line end");

endmodule

// ===== rtl/srle_out_reg.sv =====
module srle_out_reg
	import srle_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  srle_res_t            in_res,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast,
	output logic                 m_tuser
);

	logic      valid_q;
	srle_res_t res_q;

	assign in_ready = ~valid_q | m_tready;

	// Hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = M_TDATA_W'({res_q.start_column, res_q.row,
		res_q.run_length, res_q.color_index});
	assign m_tlast  = res_q.end_of_line;
	assign m_tuser  = res_q.overflow;

endmodule

// ===== rtl/subtitle_rle_run_decoder_unit.sv =====
// Channel  | Direction | Word contents
// ---------+-----------+----------------------------------------------------------
// s_*      | in        | tdata: data_byte[7:0]; tlast: last byte of the object
// m_*      | out       | tdata: color_index, run_length, row, start_column; tlast:
//          |           | end of line; tuser: overflow
// APB      | in/out    | 0x0 image_width, 0x4 image_height (16 bits each)
//
// One byte is accepted per cycle while the result register is not stalled; the
// decode is short logic between the input register and the result register, so
// a result word is held in the result register while it is valid on m_*.
// Reset returns the decoder to the start of an object with width 1920 and
// height 1080.
// A stalled result register holds the input register, which stalls s_tready.
module subtitle_rle_run_decoder_unit
	import srle_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [BYTE_W-1:0]    s_tdata,   // data_byte[7:0]
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // color_index[7:0], run_length[21:8],
	                                        // row[37:22], start_column[53:38]
	output logic                 m_tlast,
	output logic                 m_tuser    // overflow
);

	srle_cfg_t cfg;
	srle_res_t res;
	logic      res_valid;
	logic      res_ready;

	srle_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	srle_decode #(
		.COORD_BITS (COORD_BITS)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	srle_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_ready (res_ready),
		.in_res   (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
